[rtl/rvv_pkg.sv]
// Package with constants and helper functions for the radial velocity block.
package rvv_pkg;

  // Pi in Q.30, used to turn the residual angle into radians in Q.61.
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  // CORDIC start value, the inverse gain in Q.30.
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  // Pi in Q.61.
  localparam logic signed [63:0] PiQ61 = 64'sh6487ED5110B4611A;

  // Arctangent of 2^-i in Q.61, by its power series.
  function automatic logic signed [63:0] step_angle(input int i);
    logic signed [63:0] sum;
    logic [63:0] t;
    int e;
    sum = '0;
    if (i == 0) begin
      sum = PiQ61 >>> 2;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 61) begin
          t = (64'd1 << (61 - e)) / 64'(2 * k + 1);
          if (k % 2 == 1) begin
            sum = sum - $signed(t);
          end else begin
            sum = sum + $signed(t);
          end
        end
      end
    end
    return sum;
  endfunction

  // Data handed from one rotation cell to the next.
  typedef struct packed {
    logic               vld;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [63:0] z;
    logic        [1:0]  quad;
  } rvv_rot_t;

endpackage

[rtl/rvv_cell.sv]
// One CORDIC rotation cell: a single micro-rotation and a register stage.
module rvv_cell #(
  parameter int Stage = 0,
  parameter int PayW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rvv_pkg::rvv_rot_t    rot_i,
  input  logic [PayW-1:0]      pay_i,
  output rvv_pkg::rvv_rot_t    rot_o,
  output logic [PayW-1:0]      pay_o
);
  import rvv_pkg::*;

  localparam logic signed [63:0] StepA = step_angle(Stage);

  rvv_rot_t        rot_d, rot_q;
  logic            vld_q;
  logic [PayW-1:0] pay_q;

  // Rotate toward zero residual angle.
  always_comb begin
    rot_d = rot_i;
    if (!rot_i.z[63]) begin
      rot_d.x = rot_i.x - (rot_i.y >>> Stage);
      rot_d.y = rot_i.y + (rot_i.x >>> Stage);
      rot_d.z = rot_i.z - StepA;
    end else begin
      rot_d.x = rot_i.x + (rot_i.y >>> Stage);
      rot_d.y = rot_i.y - (rot_i.x >>> Stage);
      rot_d.z = rot_i.z + StepA;
    end
  end

  // Valid flag is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= rot_i.vld;
    end
  end

  // The rest is payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
      pay_q <= pay_i;
    end
  end

  // The valid flag is the top bit of the packed struct.
  assign rot_o = {vld_q, rot_q[$bits(rvv_rot_t)-2:0]};
  assign pay_o = pay_q;

endmodule

[rtl/radial_velocity_with_variance.sv]
// Top level: CORDIC cell chain followed by the projection and variance stages.
//
// One detection is accepted per clock cycle and one result leaves per cycle.
// The path holds one register stage for the quadrant reduction, one per
// CORDIC cell in the chain, and five for rounding, the products, the
// azimuth term and the final sum. The whole pipeline advances together and
// freezes while the output is stalled with a valid result in its last stage;
// the input is stalled in exactly those cycles, and empty stages are not
// squeezed out while frozen. With no output stall, throughput is one beat a
// cycle.
module radial_velocity_with_variance #(
  parameter int ANGLE_BITS      = 16,
  parameter int VELOCITY_BITS   = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ANGLE_BITS-1:0]    azimuth_angle_i,
  input  logic signed [VELOCITY_BITS-1:0] vel_x_i,
  input  logic signed [VELOCITY_BITS-1:0] vel_y_i,
  input  logic        [23:0]              var_vel_x_i,
  input  logic        [23:0]              var_vel_y_i,
  input  logic signed [23:0]              cov_vel_xy_i,
  input  logic        [15:0]              var_azimuth_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [17:0]              range_rate_o,
  output logic        [31:0]              range_rate_variance_o
);
  import rvv_pkg::*;

  localparam int VW   = VELOCITY_BITS;
  localparam int PayW = 2 * VW + 24 + 24 + 24 + 16;
  localparam int N    = TRIG_ITERATIONS;

  // Global advance: move unless the last stage holds a stalled result.
  logic en;
  logic v5_q;
  assign en         = !(v5_q && out_stall_i);
  assign in_stall_o = !en;

  // Quadrant reduction stage.
  logic [31:0]        u, r;
  logic [1:0]         q;
  logic signed [63:0] z0;
  logic               v0_q;
  rvv_rot_t           rot0_q;
  logic [PayW-1:0]    pay0_q;

  always_comb begin
    u  = {azimuth_angle_i, {(32-ANGLE_BITS){1'b0}}};
    q  = 2'((u + 32'h2000_0000) >> 30);
    r  = u - {q, 30'd0};
    z0 = 64'($signed(r)) * $signed({1'b0, PiQ30});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot0_q <= '{vld: in_valid_i, x: GainQ30, y: '0, z: z0, quad: q};
      pay0_q <= {vel_x_i, vel_y_i, var_vel_x_i, var_vel_y_i, cov_vel_xy_i,
                 var_azimuth_i};
    end
  end

  // CORDIC cell chain.
  rvv_rot_t        rot_c [N+1];
  logic [PayW-1:0] pay_c [N+1];
  assign rot_c[0] = {v0_q, rot0_q[$bits(rvv_rot_t)-2:0]};
  assign pay_c[0] = pay0_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rvv_cell #(.Stage(i), .PayW(PayW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .rot_i (rot_c[i]),
      .pay_i (pay_c[i]),
      .rot_o (rot_c[i+1]),
      .pay_o (pay_c[i+1])
    );
  end

  rvv_rot_t rc;
  logic signed [VW-1:0] vx, vy;
  logic [23:0] pxx, pyy, vaz24;
  logic signed [23:0] cxy;
  logic [15:0] vaz;
  assign rc = rot_c[N];
  assign {vx, vy, pxx, pyy, cxy, vaz} = pay_c[N];
  assign vaz24 = {8'd0, vaz};

  // Stage 1: round, clamp and map back to the quadrant.
  logic signed [33:0] cr, sr;
  logic signed [16:0] cc, sc, co, si;
  always_comb begin
    cr = (rc.x + 34'sd16384) >>> 15;
    sr = (rc.y + 34'sd16384) >>> 15;
    cc = (cr > 34'sd32768) ? 17'sd32768 : (cr < -34'sd32768) ? -17'sd32768 : 17'(cr);
    sc = (sr > 34'sd32768) ? 17'sd32768 : (sr < -34'sd32768) ? -17'sd32768 : 17'(sr);
    case (rc.quad)
      2'd0:    begin co = cc;  si = sc;  end
      2'd1:    begin co = -sc; si = cc;  end
      2'd2:    begin co = -cc; si = -sc; end
      default: begin co = sc;  si = -cc; end
    endcase
  end

  logic v1_q;
  logic signed [16:0] c1_q, s1_q;
  logic signed [VW-1:0] vx1_q, vy1_q;
  logic [23:0] pxx1_q, pyy1_q;
  logic signed [23:0] cxy1_q;
  logic [15:0] vaz1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= co; s1_q <= si; vx1_q <= vx; vy1_q <= vy;
      pxx1_q <= pxx; pyy1_q <= pyy; cxy1_q <= cxy; vaz1_q <= vaz24[15:0];
    end
  end

  // Stage 2: first products.
  localparam int PW = VW + 17;
  logic v2_q;
  logic signed [PW-1:0] cvx2_q, svy2_q, cvy2_q, svx2_q;
  logic signed [33:0] cc2_q, ss2_q, cs2_q;
  logic [23:0] pxx2_q, pyy2_q;
  logic signed [23:0] cxy2_q;
  logic [15:0] vaz2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cvx2_q <= PW'(c1_q) * PW'(vx1_q);
      svy2_q <= PW'(s1_q) * PW'(vy1_q);
      cvy2_q <= PW'(c1_q) * PW'(vy1_q);
      svx2_q <= PW'(s1_q) * PW'(vx1_q);
      cc2_q  <= 34'(c1_q) * 34'(c1_q);
      ss2_q  <= 34'(s1_q) * 34'(s1_q);
      cs2_q  <= 34'(c1_q) * 34'(s1_q);
      pxx2_q <= pxx1_q; pyy2_q <= pyy1_q; cxy2_q <= cxy1_q; vaz2_q <= vaz1_q;
    end
  end

  // Stage 3: range rate, azimuth Jacobian term, variance products.
  localparam int SW = PW + 1;
  logic signed [SW-1:0] rrs, js;
  logic signed [SW-1:0] rr_sh, j_sh;
  logic signed [17:0] rr_sat;
  always_comb begin
    rrs   = SW'(cvx2_q) + SW'(svy2_q) + SW'(16384);
    js    = SW'(cvy2_q) - SW'(svx2_q) + SW'(16384);
    rr_sh = rrs >>> 15;
    j_sh  = js >>> 15;
    if (rr_sh > SW'(131071))       rr_sat = 18'sd131071;
    else if (rr_sh < -SW'(131072)) rr_sat = -18'sd131072;
    else                           rr_sat = 18'(rr_sh);
  end

  logic v3_q;
  logic signed [17:0] rr3_q;
  logic [SW-1:0] aj3_q;
  logic signed [58:0] txx3_q, tyy3_q, txy3_q;
  logic [15:0] vaz3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rr3_q  <= rr_sat;
      aj3_q  <= j_sh[SW-1] ? SW'(-j_sh) : SW'(j_sh);
      txx3_q <= 59'(cc2_q) * 59'($signed({1'b0, pxx2_q}));
      tyy3_q <= 59'(ss2_q) * 59'($signed({1'b0, pyy2_q}));
      txy3_q <= 59'(cs2_q) * 59'(cxy2_q) * 59'sd2;
      vaz3_q <= vaz2_q;
    end
  end

  // Stage 4: square of the Jacobian term and velocity part.
  logic v4_q;
  logic signed [17:0] rr4_q;
  logic [2*SW-1:0] sq4_q;
  logic signed [60:0] vel4_q;
  logic [15:0] vaz4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rr4_q  <= rr3_q;
      sq4_q  <= aj3_q * aj3_q;
      vel4_q <= 61'(txx3_q) + 61'(tyy3_q) + 61'(txy3_q);
      vaz4_q <= vaz3_q;
    end
  end

  // Stage 5: azimuth term, with saturation when the product passes 64 bits, and the clamped final sum.
  localparam int QW = 2 * SW + 16;
  logic [QW-1:0] prod;
  logic [63:0] prod64;
  logic [44:0] term;
  logic signed [31:0] pv;
  logic signed [46:0] tot;
  always_comb begin
    prod   = QW'(sq4_q) * QW'(vaz4_q);
    prod64 = (QW > 64 && (prod >> 64) != '0) ? '1 : 64'(prod);
    term   = 45'(prod64 >> 20) + 45'(prod64[19]);
    pv     = 32'((vel4_q + 61'sd536870912) >>> 30);
    tot    = 47'(pv) + $signed({2'b0, term});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      range_rate_o <= rr4_q;
      if (tot < 0)                    range_rate_variance_o <= '0;
      else if (tot > 47'sd4294967295) range_rate_variance_o <= '1;
      else                            range_rate_variance_o <= 32'(tot);
    end
  end

  // Valid chain through the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= rc.vld; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  assign out_valid_o = v5_q;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v5_q && out_stall_i)) else $error("stall without full output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(range_rate_variance_o)))
    else $error("stalled result changed");
  a_chain_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && v4_q) |=> out_valid_o) else $error("result lost in last stage");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the radial velocity and variance pipeline.
`timescale 1ns / 1ps

module testbench;
  import rvv_pkg::*;

  localparam int     TrigIters   = 16;
  localparam int     Latency     = TrigIters + 6;
  localparam int     RandomBeats = 530;
  localparam int     IdleLimit   = 3000;
  localparam int     LongHold    = 300;
  localparam longint PiQ30Own    = 64'sd3373259426;
  localparam longint GainOwn     = 64'sd652032874;
  localparam longint VarMax      = 64'sd4294967295;

  // One detection with an optional hand-written expected result.
  typedef struct {
    logic signed [15:0] ang;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic        [23:0] pxx;
    logic        [23:0] pyy;
    logic signed [23:0] cxy;
    logic        [15:0] vaz;
    bit                 typed;
    logic signed [17:0] exp_rr;
    logic        [31:0] exp_var;
  } detection_t;

  typedef struct {
    logic signed [17:0] rr;
    logic        [31:0] var_out;
  } projection_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] azimuth_angle_i = '0;
  logic signed [15:0] vel_x_i = '0;
  logic signed [15:0] vel_y_i = '0;
  logic [23:0] var_vel_x_i = '0;
  logic [23:0] var_vel_y_i = '0;
  logic signed [23:0] cov_vel_xy_i = '0;
  logic [15:0] var_azimuth_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [17:0] range_rate_o;
  logic [31:0] range_rate_variance_o;

  // Sideband that travels with the current input beat.
  bit                 beat_typed = 1'b0;
  logic signed [17:0] beat_exp_rr = '0;
  logic        [31:0] beat_exp_var = '0;

  projection_t pending_q[$];
  longint      arctan_q61[TrigIters];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          hold_cycles = 0;

  radial_velocity_with_variance dut (.*);

  always #10 clk_i = ~clk_i;

  // Arctangent of 2^-i in Q.61 from its power series.
  function automatic longint arctan_pow2(input int i);
    longint sum;
    longint unsigned t;
    int e;
    sum = 0;
    if (i == 0) return 64'sh6487ED5110B4611A >>> 2;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 61) break;
      t = (64'd1 << (61 - e)) / longint'(2 * k + 1);
      if (k % 2 == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    return sum;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Projects the velocity onto the line of sight and propagates its variance.
  function automatic projection_t project_detection(input detection_t d);
    projection_t res;
    logic [31:0] u, r;
    logic [1:0]  q;
    longint z, x, y, dx, dy, c0, s0, c, s, dot, vel, pv, j, tot;
    longint unsigned aj, prod, term;
    u = {d.ang, 16'b0};
    q = 2'((u + 32'h2000_0000) >> 30);
    r = u - {q, 30'b0};
    z = longint'($signed(r)) * PiQ30Own;
    x = GainOwn;
    y = 0;
    for (int i = 0; i < TrigIters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q61[i];
      end else begin
        x += dx; y -= dy; z += arctan_q61[i];
      end
    end
    c0 = clamp((x + 16384) >>> 15, -32768, 32768);
    s0 = clamp((y + 16384) >>> 15, -32768, 32768);
    case (q)
      2'd0: begin c = c0;  s = s0;  end
      2'd1: begin c = -s0; s = c0;  end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
    dot = c * longint'(d.vx) + s * longint'(d.vy) + 16384;
    res.rr = 18'(clamp(dot >>> 15, -131072, 131071));
    vel = c * c * longint'(d.pxx) + s * s * longint'(d.pyy) + 2 * c * s * longint'(d.cxy);
    pv = (vel + 64'sd536870912) >>> 30;
    j = (longint'(d.vy) * c - longint'(d.vx) * s + 16384) >>> 15;
    aj = j < 0 ? -j : j;
    prod = aj * aj * longint'(d.vaz);
    term = (prod >> 20) + ((prod >> 19) & 1);
    tot = clamp(pv + longint'(term), 0, VarMax);
    res.var_out = 32'(tot);
    return res;
  endfunction

  function automatic detection_t random_detection();
    detection_t d;
    d.ang = 16'($urandom);
    d.vx  = ($urandom_range(0, 3) == 0) ? 16'($signed(8'($urandom))) : 16'($urandom);
    d.vy  = ($urandom_range(0, 3) == 0) ? 16'($signed(8'($urandom))) : 16'($urandom);
    d.pxx = 24'($urandom);
    d.pyy = 24'($urandom);
    d.cxy = 24'($urandom);
    d.vaz = 16'($urandom);
    if ($urandom_range(0, 9) == 0) d.pxx = 24'hFF_FFFF;
    if ($urandom_range(0, 9) == 0) d.cxy = ($urandom_range(0, 1) == 1) ? 24'h80_0000 : 24'h7F_FFFF;
    d.typed = 1'b0;
    d.exp_rr = '0;
    d.exp_var = '0;
    return d;
  endfunction

  // Presents one beat at the falling edge and holds it until it is taken.
  task automatic send_detection(input detection_t d);
    int gap;
    case ($urandom_range(0, 19))
      0: gap = $urandom_range(10, 40);
      1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
      default: gap = 0;
    endcase
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    azimuth_angle_i <= d.ang;
    vel_x_i <= d.vx;
    vel_y_i <= d.vy;
    var_vel_x_i <= d.pxx;
    var_vel_y_i <= d.pyy;
    cov_vel_xy_i <= d.cxy;
    var_azimuth_i <= d.vaz;
    beat_typed <= d.typed;
    beat_exp_rr <= d.exp_rr;
    beat_exp_var <= d.exp_var;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Queues the expectation for every input beat the block takes.
  always @(posedge clk_i) begin
    detection_t d;
    projection_t p;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      d = '{azimuth_angle_i, vel_x_i, vel_y_i, var_vel_x_i, var_vel_y_i,
            cov_vel_xy_i, var_azimuth_i, 1'b0, '0, '0};
      if (beat_typed) begin
        p.rr = beat_exp_rr;
        p.var_out = beat_exp_var;
      end else begin
        p = project_detection(d);
      end
      pending_q.push_back(p);
    end
  end

  // Compares each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    projection_t p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat rr=%0d var=%0d",
                                       range_rate_o, range_rate_variance_o);
      end else begin
        p = pending_q.pop_front();
        if (p.rr !== range_rate_o || p.var_out !== range_rate_variance_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rr exp %0d got %0d, var exp %0d got %0d",
                     p.rr, range_rate_o, p.var_out, range_rate_variance_o);
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and long holds on request.
  initial begin
    int phase_left;
    bit quiet;
    phase_left = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        quiet = $urandom_range(0, 2) == 0;
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        hold_cycles = $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= $urandom_range(0, 3) == 0;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Directed table, then random detections, then drain and report.
  initial begin
    detection_t table_rows[$];
    detection_t d;
    for (int i = 0; i < TrigIters; i++) arctan_q61[i] = arctan_pow2(i);
    // Zero motion and zero covariance give zero in both outputs at any angle.
    table_rows.push_back('{16'sh0000, 0, 0, 0, 0, 0, 0, 1'b1, 18'sd0, 32'd0});
    table_rows.push_back('{-16'sd32768, 0, 0, 0, 0, 0, 16'hFFFF, 1'b1, 18'sd0, 32'd0});
    table_rows.push_back('{16'sd32767, 0, 0, 0, 0, 0, 16'hFFFF, 1'b1, 18'sd0, 32'd0});
    table_rows.push_back('{16'sd16384, 0, 0, 0, 0, 0, 0, 1'b1, 18'sd0, 32'd0});
    // Extremes of the angle, the velocity and the covariance fields.
    table_rows.push_back('{16'sd0, 16'sd32767, -16'sd32768, 24'hFFFFFF, 24'hFFFFFF,
                           24'sh7FFFFF, 16'hFFFF, 1'b0, '0, '0});
    table_rows.push_back('{-16'sd16384, -16'sd32768, -16'sd32768, 24'hFFFFFF, 24'hFFFFFF,
                           24'sh7FFFFF, 16'hFFFF, 1'b0, '0, '0});
    table_rows.push_back('{16'sd8192, 16'sd32767, 16'sd32767, 24'hFFFFFF, 24'hFFFFFF,
                           24'sh7FFFFF, 16'hFFFF, 1'b0, '0, '0});
    table_rows.push_back('{-16'sd8192, -16'sd32768, 16'sd32767, 0, 0, 0, 16'hFFFF,
                           1'b0, '0, '0});
    table_rows.push_back('{16'sd24576, 16'sd32767, -16'sd32768, 0, 0, 0, 0, 1'b0, '0, '0});
    table_rows.push_back('{-16'sd24576, 16'sd100, 16'sd200, 0, 0, 24'sh800000, 0,
                           1'b0, '0, '0});
    table_rows.push_back('{16'sd8192, 16'sd1, -16'sd1, 24'h0, 24'h0, 24'sh800000, 16'h1,
                           1'b0, '0, '0});
    table_rows.push_back('{-16'sd8193, 16'sd256, 16'sd256, 24'h1, 24'h1, -24'sd1, 16'h8000,
                           1'b0, '0, '0});
    table_rows.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 24'hAAAAAA, 24'h555555,
                           24'sh555555, 16'hAAAA, 1'b0, '0, '0});
    table_rows.push_back('{16'shAAAA, 16'sh5555, 16'shAAAA, 24'h555555, 24'hAAAAAA,
                           24'shAAAAAA, 16'h5555, 1'b0, '0, '0});
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (table_rows[i]) send_detection(table_rows[i]);
    // Let everything drain before the random part.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    for (int n = 0; n < RandomBeats; n++) begin
      if (n == 100) hold_cycles = LongHold;
      if (n == 300) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait (pending_q.size() == 0);
      end
      d = random_detection();
      send_detection(d);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

[radial_velocity_with_variance.f]
rtl/rvv_pkg.sv
rtl/rvv_cell.sv
rtl/radial_velocity_with_variance.sv
test/testbench.sv
